/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0] CH_NEWLINE     = 8'h0A;
  localparam logic [7:0] CH_RETURN      = 8'h0D;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] COLOR_AT_RESET = 8'h07;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic fill_step;
    logic capture;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic read_req;
    logic scroll_req;
    logic clear_last;
    logic fill_last;
    logic out_free;
  } tcw_status_t;

endpackage

/* rtl/tcw_ctrl.sv */
`timescale 1ns / 1ps
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::tcw_status_t st,
  output tcw_pkg::tcw_cmd_t    cmd
);
  import tcw_pkg::*;

  tcw_state_t state;
  tcw_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (st.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (st.read_req) begin
            state_next = ST_READ;
          end else if (st.scroll_req) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_FILL: begin
        if (st.fill_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd.accept     = (state == ST_IDLE) && in_valid;
    cmd.clear_step = (state == ST_CLEAR);
    cmd.fill_step  = (state == ST_FILL);
    cmd.capture    = (state == ST_READ);
    cmd.load_out   = (state == ST_DONE) && st.out_free;
  end

`ifndef SYNTH
  a_scroll_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && !st.read_req && st.scroll_req |=> state == ST_FILL)
    else $error("scrolling put did not start the row fill");

  a_read_waits: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && st.read_req |=> state == ST_READ ##1 state == ST_DONE)
    else $error("read did not pass through the data stage");

  a_fill_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL && st.fill_last |=> state == ST_DONE)
    else $error("row fill did not finish");
`endif

endmodule

/* rtl/tcw_dp.sv */
`timescale 1ns / 1ps
module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcw_pkg::tcw_cmd_t    cmd,
  output tcw_pkg::tcw_status_t st,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_data,
  input  logic                 func,
  input  logic [7:0]           char_code,
  input  logic [4:0]           read_row,
  input  logic [6:0]           read_col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           echo_char,
  output logic [7:0]           cell_color,
  output logic [6:0]           cursor_col,
  output logic [4:0]           cursor_row,
  output logic                 scrolled
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data;

  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [RW-1:0] top_row;
  logic [7:0]    color;
  logic [AW-1:0] clr_addr;
  logic [CW-1:0] fill_col;
  logic [RW-1:0] fill_row;

  logic [7:0]    res_char;
  logic [7:0]    res_color;
  logic          res_scrolled;
  logic          res_ok;

  logic          is_nl;
  logic          is_cr;
  logic [CW:0]   col_inc;
  logic          wrap;
  logic          row_adv;
  logic          last_row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [RW-1:0] top_next;
  logic [RW:0]   put_sum;
  logic [RW-1:0] put_phys;
  logic [RW:0]   rd_sum;
  logic [RW-1:0] rd_phys;
  logic          rd_in_range;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] fill_addr;
  logic          do_put;
  logic          do_read;
  logic          put_we;
  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;

  always_comb begin
    do_put   = cmd.accept && (func == FUNC_PUT);
    do_read  = cmd.accept && (func == FUNC_READ);
    is_nl    = (char_code == CH_NEWLINE);
    is_cr    = (char_code == CH_RETURN);
    col_inc  = {1'b0, cur_col} + (CW+1)'(1);
    wrap     = !is_nl && !is_cr && (col_inc == (CW+1)'(COLUMNS));
    row_adv  = is_nl || wrap;
    last_row = (cur_row == RW'(ROWS - 1));
    col_next = (is_nl || is_cr || wrap) ? '0 : col_inc[CW-1:0];
    row_next = (row_adv && !last_row) ? cur_row + RW'(1) : cur_row;
    top_next = (top_row == RW'(ROWS - 1)) ? '0 : top_row + RW'(1);

    put_sum  = {1'b0, cur_row} + {1'b0, top_row};
    put_phys = (put_sum >= (RW+1)'(ROWS)) ? RW'(put_sum - (RW+1)'(ROWS)) : put_sum[RW-1:0];
    rd_sum   = {1'b0, RW'(read_row)} + {1'b0, top_row};
    rd_phys  = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : rd_sum[RW-1:0];
    rd_in_range = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLUMNS));

    put_addr  = AW'(put_phys) * AW'(COLUMNS) + AW'(cur_col);
    rd_addr   = AW'(rd_phys) * AW'(COLUMNS) + AW'(CW'(read_col));
    fill_addr = AW'(fill_row) * AW'(COLUMNS) + AW'(fill_col);

    put_we = do_put && !is_nl && !is_cr;
    we     = cmd.clear_step || cmd.fill_step || put_we;
    if (cmd.clear_step) begin
      wa = clr_addr;
      wd = '0;
    end else if (cmd.fill_step) begin
      wa = fill_addr;
      wd = {color, CH_SPACE};
    end else begin
      wa = put_addr;
      wd = {color, char_code};
    end

    st.read_req   = (func == FUNC_READ);
    st.scroll_req = row_adv && last_row;
    st.clear_last = (clr_addr == AW'(CELLS - 1));
    st.fill_last  = (fill_col == CW'(COLUMNS - 1));
    st.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col   <= '0;
      cur_row   <= '0;
      top_row   <= '0;
      color     <= COLOR_AT_RESET;
      clr_addr  <= '0;
      fill_col  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) color <= cfg_data;
      if (cmd.clear_step) clr_addr <= clr_addr + AW'(1);
      if (do_put) begin
        cur_col <= col_next;
        cur_row <= row_next;
        if (st.scroll_req) begin
          top_row  <= top_next;
          fill_col <= '0;
        end
      end else if (cmd.fill_step) begin
        fill_col <= fill_col + CW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_put) begin
      res_char     <= char_code;
      res_color    <= color;
      res_scrolled <= st.scroll_req;
      fill_row     <= top_row;
    end
    if (do_read) begin
      res_scrolled <= 1'b0;
      res_ok       <= rd_in_range;
    end
    if (cmd.capture) begin
      res_char  <= res_ok ? rd_data[7:0] : '0;
      res_color <= res_ok ? rd_data[15:8] : '0;
    end
    if (cmd.load_out) begin
      echo_char  <= res_char;
      cell_color <= res_color;
      cursor_col <= 7'(cur_col);
      cursor_row <= 5'(cur_row);
      scrolled   <= res_scrolled;
    end
  end

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cur_col} < (CW+1)'(COLUMNS))
    else $error("cursor column outside the screen");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cur_row} < (RW+1)'(ROWS) && {1'b0, top_row} < (RW+1)'(ROWS))
    else $error("cursor or top row outside the screen");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    do_put && st.scroll_req |=> cur_row == RW'(ROWS - 1) && fill_col == '0)
    else $error("scroll left the cursor off the last row");

  a_fill_steady: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |=> $stable(top_row) && $stable(cur_row))
    else $error("screen origin moved during row fill");
`endif

endmodule

/* rtl/text_console_writer_core.sv */
`timescale 1ns / 1ps
// Text console writer: a screen of ROWS x COLUMNS character cells (attribute byte high,
// character byte low) with a cursor. A put (func 0) stores char_code in the configured color at the
// cursor, or handles newline and carriage return; a read (func 1) returns one cell. After
// reset the block clears the whole store, one cell per cycle, with in_ready low;
// configuration writes are taken at any time. A read passes through an extra
// state, since the cell store is read through a registered port. A put that
// scrolls moves the screen origin by one row in a circular row map and fills the
// freed row with spaces, one cell per cycle.
// Results sit in an output register until taken.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] echo_char,
  output logic [7:0] cell_color,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic       scrolled
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t st;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .func       (func),
    .char_code  (char_code),
    .read_row   (read_row),
    .read_col   (read_col),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .echo_char  (echo_char),
    .cell_color (cell_color),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

endmodule

/* tb/tb_text_console_writer_core.sv */
`timescale 1ns / 1ps
module tb_text_console_writer_core;
  import tcw_pkg::*;

  localparam int COL_COUNT = DEF_COLUMNS;
  localparam int ROW_COUNT = DEF_ROWS;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int TAIL_CYCLES = 120;
  localparam int PHASE_COUNT = 7;
  localparam int PHASE_ITEMS = 147;
  localparam int DIRECTED_COUNT = 22;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } console_item_t;

  typedef struct packed {
    logic [7:0] echo_char;
    logic [7:0] cell_color;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
  } console_result_t;

  typedef struct packed {
    console_item_t   item;
    logic            typed;
    console_result_t want;
  } stim_row_t;

  localparam console_result_t NO_REF = '0;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       func;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] echo_char;
  logic [7:0] cell_color;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic       scrolled;

  text_console_writer_core #(
    .COLUMNS(COL_COUNT),
    .ROWS(ROW_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .char_code(char_code),
    .read_row(read_row),
    .read_col(read_col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .echo_char(echo_char),
    .cell_color(cell_color),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .scrolled(scrolled)
  );

  always #6 clk = ~clk;

  // screen mirror and cursor tracked by the predictor
  logic [15:0]     screen_mirror [ROW_COUNT*COL_COUNT];
  int              cur_col;
  int              cur_row;
  logic [7:0]      shadow_color;
  console_result_t pending_results [$];

  int  mismatches;
  int  result_count;
  int  put_count;
  int  read_count;
  int  scroll_count;
  int  color_count;
  int  idle_cycles;
  bit  sender_calm;
  bit  rx_calm;

  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    '{'{FUNC_READ, 8'h00, 5'd0, 7'd0}, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
    '{'{FUNC_READ, 8'hFF, 5'd24, 7'd79}, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
    '{'{FUNC_READ, 8'h00, 5'd25, 7'd0}, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
    '{'{FUNC_READ, 8'h00, 5'd0, 7'd80}, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
    '{'{FUNC_READ, 8'h5A, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
    '{'{FUNC_PUT, 8'h41, 5'd31, 7'd127}, 1'b1, '{8'h41, COLOR_AT_RESET, 7'd1, 5'd0, 1'b0}},
    '{'{FUNC_PUT, 8'h00, 5'd0, 7'd0}, 1'b1, '{8'h00, COLOR_AT_RESET, 7'd2, 5'd0, 1'b0}},
    '{'{FUNC_PUT, 8'hFF, 5'd5, 7'd3}, 1'b1, '{8'hFF, COLOR_AT_RESET, 7'd3, 5'd0, 1'b0}},
    '{'{FUNC_PUT, 8'h1B, 5'd0, 7'd0}, 1'b1, '{8'h1B, COLOR_AT_RESET, 7'd4, 5'd0, 1'b0}},
    '{'{FUNC_PUT, CH_RETURN, 5'd0, 7'd0}, 1'b1,
      '{CH_RETURN, COLOR_AT_RESET, 7'd0, 5'd0, 1'b0}},
    '{'{FUNC_PUT, 8'h42, 5'd0, 7'd0}, 1'b1, '{8'h42, COLOR_AT_RESET, 7'd1, 5'd0, 1'b0}},
    '{'{FUNC_PUT, CH_NEWLINE, 5'd0, 7'd0}, 1'b1,
      '{CH_NEWLINE, COLOR_AT_RESET, 7'd0, 5'd1, 1'b0}},
    '{'{FUNC_PUT, 8'h09, 5'd0, 7'd0}, 1'b1, '{8'h09, COLOR_AT_RESET, 7'd1, 5'd1, 1'b0}},
    '{'{FUNC_READ, 8'h00, 5'd0, 7'd0}, 1'b0, NO_REF},
    '{'{FUNC_READ, 8'h00, 5'd0, 7'd1}, 1'b0, NO_REF},
    '{'{FUNC_READ, 8'h00, 5'd0, 7'd2}, 1'b0, NO_REF},
    '{'{FUNC_READ, 8'h00, 5'd0, 7'd3}, 1'b0, NO_REF},
    '{'{FUNC_READ, 8'h00, 5'd1, 7'd0}, 1'b0, NO_REF},
    '{'{FUNC_READ, 8'h00, 5'd0, 7'd4}, 1'b0, NO_REF},
    '{'{FUNC_PUT, 8'h7F, 5'd0, 7'd0}, 1'b0, NO_REF},
    '{'{FUNC_PUT, 8'h80, 5'd16, 7'd64}, 1'b0, NO_REF},
    '{'{FUNC_READ, 8'h00, 5'd1, 7'd2}, 1'b0, NO_REF}
  };

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $time, result_count, msg);
    mismatches++;
  endtask

  function automatic console_result_t console_step(input console_item_t it);
    console_result_t r;
    int idx;
    r = '0;
    if (it.func == FUNC_READ) begin
      if (it.read_row < ROW_COUNT && it.read_col < COL_COUNT) begin
        idx = it.read_row * COL_COUNT + it.read_col;
        r.echo_char = screen_mirror[idx][7:0];
        r.cell_color = screen_mirror[idx][15:8];
      end
    end else begin
      r.echo_char = it.char_code;
      r.cell_color = shadow_color;
      if (it.char_code == CH_NEWLINE) begin
        cur_col = 0;
        cur_row++;
      end else if (it.char_code == CH_RETURN) begin
        cur_col = 0;
      end else begin
        screen_mirror[cur_row * COL_COUNT + cur_col] = {shadow_color, it.char_code};
        cur_col++;
      end
      if (cur_col >= COL_COUNT) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROW_COUNT) begin
        for (idx = 0; idx < (ROW_COUNT - 1) * COL_COUNT; idx++)
          screen_mirror[idx] = screen_mirror[idx + COL_COUNT];
        for (idx = (ROW_COUNT - 1) * COL_COUNT; idx < ROW_COUNT * COL_COUNT; idx++)
          screen_mirror[idx] = {shadow_color, CH_SPACE};
        cur_row = ROW_COUNT - 1;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_col = cur_col[6:0];
    r.cursor_row = cur_row[4:0];
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input console_item_t it, input logic typed,
                           input console_result_t want);
    int gap;
    console_result_t predicted;
    gap = sender_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= it.func;
    char_code <= it.char_code;
    read_row  <= it.read_row;
    read_col  <= it.read_col;
    do @(posedge clk); while (!in_ready);
    predicted = console_step(it);
    pending_results.push_back(typed ? want : predicted);
    if (it.func == FUNC_READ) read_count++;
    else put_count++;
    if (predicted.scrolled) scroll_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_color(input logic [7:0] color);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (!cfg_ready);
    shadow_color = color;
    color_count++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_put(input logic [7:0] ch);
    console_item_t it;
    it.func = FUNC_PUT;
    it.char_code = ch;
    it.read_row = 5'($urandom_range(0, 31));
    it.read_col = 7'($urandom_range(0, 127));
    send_item(it, 1'b0, NO_REF);
  endtask

  task automatic send_read();
    console_item_t it;
    int pick;
    pick = $urandom_range(0, 7);
    it.func = FUNC_READ;
    it.char_code = 8'($urandom_range(0, 255));
    it.read_row = 5'($urandom_range(0, ROW_COUNT - 1));
    it.read_col = 7'($urandom_range(0, COL_COUNT - 1));
    if (pick == 0) begin
      it.read_row = 5'($urandom_range(0, 31));
      it.read_col = 7'($urandom_range(0, 127));
    end else if (pick < 3) begin
      it.read_row = cur_row[4:0];
    end
    send_item(it, 1'b0, NO_REF);
  endtask

  task automatic run_random(input int target);
    int sent;
    int burst;
    int n;
    int k;
    int ending;
    sent = 0;
    while (sent < target) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 29) == 0) wait_drained();
      burst = $urandom_range(0, 99);
      if (burst < 35) begin
        n = $urandom_range(0, 40);
        for (k = 0; k < n; k++)
          send_put(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(8'h20, 8'h7E)));
        ending = $urandom_range(0, 3);
        if (ending == 1 || ending == 2) send_put(CH_RETURN);
        if (ending == 0 || ending == 2) send_put(CH_NEWLINE);
        sent += n + ((ending == 2) ? 2 : (ending == 3) ? 0 : 1);
      end else if (burst < 50) begin
        // run to the right margin to force a wrap
        n = COL_COUNT - cur_col;
        for (k = 0; k < n; k++) send_put(8'($urandom_range(0, 255)));
        sent += n;
      end else if (burst < 65) begin
        n = $urandom_range(1, ROW_COUNT + 2);
        for (k = 0; k < n; k++) send_put(CH_NEWLINE);
        sent += n;
      end else begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) send_read();
        sent += n;
      end
    end
  endtask

  initial begin
    int i;
    int p;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 8'h00;
    in_valid = 1'b0;
    func = FUNC_PUT;
    char_code = 8'h00;
    read_row = 5'd0;
    read_col = 7'd0;
    for (i = 0; i < ROW_COUNT * COL_COUNT; i++) screen_mirror[i] = 16'h0000;
    cur_col = 0;
    cur_row = 0;
    shadow_color = COLOR_AT_RESET;
    sender_calm = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_COUNT; i++)
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    for (p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      write_color((p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom_range(0, 255)));
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d puts and %0d reads, %0d of them scrolling the screen",
             put_count, read_count, scroll_count);
    $display("under %0d color settings besides the reset one; %0d mismatches",
             color_count, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    console_result_t got;
    console_result_t want;
    int stall;
    out_ready = 1'b0;
    rx_calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 18);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{echo_char, cell_color, cursor_col, cursor_row, scrolled};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.echo_char !== want.echo_char)
          report_mismatch($sformatf("echo_char %h, want %h", got.echo_char, want.echo_char));
        if (got.cell_color !== want.cell_color)
          report_mismatch($sformatf("cell_color %h, want %h", got.cell_color,
                                    want.cell_color));
        if (got.cursor_col !== want.cursor_col)
          report_mismatch($sformatf("cursor_col %0d, want %0d", got.cursor_col,
                                    want.cursor_col));
        if (got.cursor_row !== want.cursor_row)
          report_mismatch($sformatf("cursor_row %0d, want %0d", got.cursor_row,
                                    want.cursor_row));
        if (got.scrolled !== want.scrolled)
          report_mismatch($sformatf("scrolled %b, want %b", got.scrolled, want.scrolled));
      end
      result_count++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
